// ===== rtl/mmcspi_pkg.sv =====
package mmcspi_pkg;

	localparam int unsigned SECTOR_BYTES = 512;

	// request codes
	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_BYTE  = 2'd3
	} cmd_t;

	// operation in progress
	typedef enum logic [1:0] {
		OP_INIT_RST  = 2'd0,
		OP_READ      = 2'd1,
		OP_WRITE     = 2'd2,
		OP_INIT_IDLE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_CLOCK  = 4'd1,
		PH_FRAME  = 4'd2,
		PH_POLL   = 4'd3,
		PH_RTOKEN = 4'd4,
		PH_RDATA  = 4'd5,
		PH_RCRC   = 4'd6,
		PH_WTOKEN = 4'd7,
		PH_WDATA  = 4'd8,
		PH_WTAIL  = 4'd9,
		PH_WBUSY  = 4'd10
	} phase_t;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_INIT_RST   = 4'd1;
	localparam logic [3:0] ST_INIT_IDLE  = 4'd2;
	localparam logic [3:0] ST_RD_INVALID = 4'd3;
	localparam logic [3:0] ST_RD_GENERAL = 4'd4;
	localparam logic [3:0] ST_TOKEN      = 4'd5;
	localparam logic [3:0] ST_SECTOR0    = 4'd6;
	localparam logic [3:0] ST_WR_INVALID = 4'd7;
	localparam logic [3:0] ST_WR_GENERAL = 4'd8;

	localparam logic [7:0] BYTE_FILL     = 8'hFF;
	localparam logic [7:0] BYTE_CRC      = 8'h95;
	localparam logic [7:0] BYTE_TOKEN    = 8'hFE;
	localparam logic [7:0] CMD_GO_IDLE   = 8'h40;
	localparam logic [7:0] CMD_SEND_OP   = 8'h41;
	localparam logic [7:0] CMD_RD_SINGLE = 8'h51;
	localparam logic [7:0] CMD_WR_SINGLE = 8'h58;
	localparam logic [7:0] RSP_READY     = 8'h00;
	localparam logic [7:0] RSP_IDLE      = 8'h01;
	localparam logic [7:0] RSP_INVALID   = 8'h40;
	localparam logic [7:0] RSP_ERROR     = 8'h99;

	localparam logic [4:0] CLOCK_BYTES   = 5'd20;
	localparam logic [4:0] FRAME_BYTES   = 5'd22;
	localparam logic [4:0] FRAME_CMD_POS = 5'd16;
	localparam logic [4:0] RCRC_BYTES    = 5'd2;
	localparam logic [4:0] WTAIL_BYTES   = 5'd3;
	localparam logic [11:0] INIT_POLLS   = 12'd128;
	localparam logic [11:0] CMD_POLLS    = 12'd16;
	localparam logic [11:0] TOKEN_POLLS  = 12'd1024;
	localparam logic [11:0] BUSY_POLLS   = 12'hFFF;
	localparam logic [11:0] SECTOR_LEN   = 12'(SECTOR_BYTES);
	localparam logic [7:0] INIT_ATTEMPTS_RESET = 8'd10;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [22:0] sector;
		logic [7:0]  miso_byte;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       chip_select;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       payload_request;
		logic [8:0] byte_index;
		logic       done_res;
		logic [3:0] status;
		logic       busy_res;
	} rsp_t;

	// byte at a given position of a command frame
	function automatic logic [7:0] frame_byte(logic [4:0] pos, logic [1:0] op,
			logic [22:0] sector);
		logic [31:0] addr;
		logic [7:0]  b;
		addr = (op == OP_READ || op == OP_WRITE) ? {sector, 9'd0} : 32'd0;
		if (pos < FRAME_CMD_POS) begin
			b = BYTE_FILL;
		end else if (pos == FRAME_CMD_POS) begin
			case (op)
				OP_INIT_RST:  b = CMD_GO_IDLE;
				OP_INIT_IDLE: b = CMD_SEND_OP;
				OP_READ:      b = CMD_RD_SINGLE;
				default:      b = CMD_WR_SINGLE;
			endcase
		end else if (pos == 5'd17) begin
			b = addr[31:24];
		end else if (pos == 5'd18) begin
			b = addr[23:16];
		end else if (pos == 5'd19) begin
			b = addr[15:8];
		end else if (pos == 5'd20) begin
			b = addr[7:0];
		end else begin
			b = BYTE_CRC;
		end
		return b;
	endfunction

endpackage

// ===== rtl/mmcspi_chan.sv =====
interface mmcspi_chan #(
	parameter type T = logic [7:0]
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mmc_spi_sector_controller.sv =====
// channel  dir  payload
// req      in   cmd, sector, miso_byte, write_byte
// rsp      out  send_valid .. busy_res, one per request
// cfg      in   init_attempts (8 bits)
//
// one request is taken per cycle while req.ready is high; its response
// is registered and shows the cycle after acceptance.
// a pending response that is not taken holds req.ready low only when the
// response register is full and rsp.ready is low.
// reset (arst_n low) returns to idle with the card deselected and
// init_attempts at 10; cfg.ready is always high.
module mmc_spi_sector_controller (
	input logic clk,
	input logic arst_n,
	mmcspi_chan.sink   req,
	mmcspi_chan.source rsp,
	mmcspi_chan.sink   cfg
);

	mmcspi_pkg::phase_t phase_q, nx_phase;
	logic [1:0]  op_q, nx_op;
	logic [4:0]  pos_q, nx_pos;
	logic [11:0] poll_q, nx_poll;
	logic [7:0]  att_q, nx_att;
	logic [22:0] sector_q, nx_sector;
	logic        sel_q, nx_sel;
	logic [7:0]  lim_q;

	mmcspi_pkg::rsp_t rsp_q, rsp_d;
	logic             rsp_v_q;
	logic             acc;

	logic [1:0]  cmd;
	logic [22:0] sec;
	logic [7:0]  miso;
	logic [7:0]  wbyte;
	logic [4:0]  pos_inc;
	logic [11:0] poll_inc;
	logic [11:0] poll_inc2;
	logic [7:0]  att_inc;
	logic        att_over;
	logic        init_op;
	logic        poll_done;
	logic        res_fail;
	logic [3:0]  res_code;

	assign cmd   = req.data.cmd;
	assign sec   = req.data.sector;
	assign miso  = req.data.miso_byte;
	assign wbyte = req.data.write_byte;

	assign req.ready = !rsp_v_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	assign pos_inc   = pos_q + 5'd1;
	assign poll_inc  = poll_q + 12'd1;
	assign poll_inc2 = poll_q + 12'd2;
	assign att_inc   = att_q + 8'd1;
	assign att_over  = att_inc >= lim_q;
	assign init_op   = op_q == mmcspi_pkg::OP_INIT_RST || op_q == mmcspi_pkg::OP_INIT_IDLE;

	// response polling after a command frame
	always_comb begin
		logic [7:0]  good;
		logic [7:0]  bad;
		logic [11:0] tries;
		good  = (op_q == mmcspi_pkg::OP_INIT_RST) ? mmcspi_pkg::RSP_IDLE
			: mmcspi_pkg::RSP_READY;
		bad   = init_op ? mmcspi_pkg::RSP_ERROR : mmcspi_pkg::RSP_INVALID;
		tries = init_op ? mmcspi_pkg::INIT_POLLS : mmcspi_pkg::CMD_POLLS;
		poll_done = miso == good || miso == bad || poll_inc >= tries;
	end

	// outcome of the last polled response byte
	always_comb begin
		res_fail = 1'b0;
		res_code = mmcspi_pkg::ST_OK;
		case (op_q)
			mmcspi_pkg::OP_INIT_RST: begin
				if (miso != mmcspi_pkg::RSP_IDLE && att_over) begin
					res_fail = 1'b1;
					res_code = mmcspi_pkg::ST_INIT_RST;
				end
			end
			mmcspi_pkg::OP_INIT_IDLE: begin
				if (miso == mmcspi_pkg::RSP_READY) begin
					res_fail = 1'b1;
				end else if (att_over) begin
					res_fail = 1'b1;
					res_code = mmcspi_pkg::ST_INIT_IDLE;
				end
			end
			default: begin
				if (miso == mmcspi_pkg::RSP_INVALID) begin
					res_fail = 1'b1;
					res_code = (op_q == mmcspi_pkg::OP_READ) ? mmcspi_pkg::ST_RD_INVALID
						: mmcspi_pkg::ST_WR_INVALID;
				end else if (miso != mmcspi_pkg::RSP_READY) begin
					res_fail = 1'b1;
					res_code = (op_q == mmcspi_pkg::OP_READ) ? mmcspi_pkg::ST_RD_GENERAL
						: mmcspi_pkg::ST_WR_GENERAL;
				end
			end
		endcase
	end

	// next state
	always_comb begin
		nx_phase  = phase_q;
		nx_op     = op_q;
		nx_pos    = pos_q;
		nx_poll   = poll_q;
		nx_att    = att_q;
		nx_sector = sector_q;
		nx_sel    = sel_q;
		case (cmd)
			mmcspi_pkg::CMD_INIT: begin
				nx_op  = mmcspi_pkg::OP_INIT_RST;
				nx_att = 8'd0;
				nx_sel = 1'b1;
				nx_pos = 5'd0;
				nx_phase = (lim_q == 8'd0) ? mmcspi_pkg::PH_IDLE : mmcspi_pkg::PH_CLOCK;
			end
			mmcspi_pkg::CMD_READ: begin
				nx_op     = mmcspi_pkg::OP_READ;
				nx_sector = sec;
				nx_sel    = 1'b0;
				nx_phase  = mmcspi_pkg::PH_FRAME;
				nx_pos    = 5'd0;
			end
			mmcspi_pkg::CMD_WRITE: begin
				if (sec == 23'd0) begin
					nx_phase = mmcspi_pkg::PH_IDLE;
				end else begin
					nx_op     = mmcspi_pkg::OP_WRITE;
					nx_sector = sec;
					nx_sel    = 1'b0;
					nx_phase  = mmcspi_pkg::PH_FRAME;
					nx_pos    = 5'd0;
				end
			end
			default: begin
				case (phase_q)
					mmcspi_pkg::PH_CLOCK: begin
						nx_pos = pos_inc;
						if (pos_inc >= mmcspi_pkg::CLOCK_BYTES) begin
							nx_sel   = 1'b0;
							nx_phase = mmcspi_pkg::PH_FRAME;
							nx_pos   = 5'd0;
						end
					end
					mmcspi_pkg::PH_FRAME: begin
						nx_pos = pos_inc;
						if (pos_inc >= mmcspi_pkg::FRAME_BYTES) begin
							nx_phase = mmcspi_pkg::PH_POLL;
							nx_poll  = 12'd0;
						end
					end
					mmcspi_pkg::PH_POLL: begin
						nx_poll = poll_inc;
						if (poll_done) begin
							if (op_q == mmcspi_pkg::OP_INIT_RST
									|| (op_q == mmcspi_pkg::OP_INIT_IDLE
									&& miso != mmcspi_pkg::RSP_READY)) begin
								nx_att = att_inc;
							end
							if (res_fail) begin
								nx_sel   = 1'b1;
								nx_phase = mmcspi_pkg::PH_IDLE;
							end else begin
								case (op_q)
									mmcspi_pkg::OP_INIT_RST: begin
										if (miso == mmcspi_pkg::RSP_IDLE) begin
											nx_op    = mmcspi_pkg::OP_INIT_IDLE;
											nx_att   = 8'd0;
											nx_sel   = 1'b0;
											nx_phase = mmcspi_pkg::PH_FRAME;
										end else begin
											nx_sel   = 1'b1;
											nx_phase = mmcspi_pkg::PH_CLOCK;
										end
										nx_pos = 5'd0;
									end
									mmcspi_pkg::OP_INIT_IDLE: begin
										nx_sel   = 1'b0;
										nx_phase = mmcspi_pkg::PH_FRAME;
										nx_pos   = 5'd0;
									end
									mmcspi_pkg::OP_READ: begin
										nx_phase = mmcspi_pkg::PH_RTOKEN;
										nx_poll  = 12'd0;
									end
									default: begin
										nx_phase = mmcspi_pkg::PH_WTOKEN;
									end
								endcase
							end
						end
					end
					mmcspi_pkg::PH_RTOKEN: begin
						nx_poll = poll_inc;
						if (miso == mmcspi_pkg::BYTE_TOKEN) begin
							nx_phase = mmcspi_pkg::PH_RDATA;
							nx_poll  = 12'd0;
						end else if (poll_inc >= mmcspi_pkg::TOKEN_POLLS) begin
							nx_sel   = 1'b1;
							nx_phase = mmcspi_pkg::PH_IDLE;
						end
					end
					mmcspi_pkg::PH_RDATA: begin
						nx_poll = poll_inc;
						if (poll_inc >= mmcspi_pkg::SECTOR_LEN) begin
							nx_phase = mmcspi_pkg::PH_RCRC;
							nx_pos   = 5'd0;
						end
					end
					mmcspi_pkg::PH_RCRC: begin
						nx_pos = pos_inc;
						if (pos_inc >= mmcspi_pkg::RCRC_BYTES) begin
							nx_sel   = 1'b1;
							nx_phase = mmcspi_pkg::PH_IDLE;
						end
					end
					mmcspi_pkg::PH_WTOKEN: begin
						nx_phase = mmcspi_pkg::PH_WDATA;
						nx_poll  = 12'd0;
					end
					mmcspi_pkg::PH_WDATA: begin
						if (poll_inc < mmcspi_pkg::SECTOR_LEN) begin
							nx_poll = poll_inc;
						end else begin
							nx_phase = mmcspi_pkg::PH_WTAIL;
							nx_pos   = 5'd0;
						end
					end
					mmcspi_pkg::PH_WTAIL: begin
						nx_pos = pos_inc;
						if (pos_inc >= mmcspi_pkg::WTAIL_BYTES) begin
							nx_phase = mmcspi_pkg::PH_WBUSY;
							nx_poll  = 12'd0;
						end
					end
					mmcspi_pkg::PH_WBUSY: begin
						nx_poll = poll_inc;
						if (miso != 8'd0 || poll_inc >= mmcspi_pkg::BUSY_POLLS) begin
							nx_sel   = 1'b1;
							nx_phase = mmcspi_pkg::PH_IDLE;
						end
					end
					default: begin
						nx_phase = mmcspi_pkg::PH_IDLE;
					end
				endcase
			end
		endcase
	end

	// response for this request
	always_comb begin
		rsp_d = '0;
		rsp_d.chip_select = nx_sel;
		rsp_d.busy_res    = nx_phase != mmcspi_pkg::PH_IDLE;
		case (cmd)
			mmcspi_pkg::CMD_INIT: begin
				if (lim_q == 8'd0) begin
					rsp_d.done_res = 1'b1;
					rsp_d.status   = mmcspi_pkg::ST_INIT_RST;
				end else begin
					rsp_d.send_valid = 1'b1;
					rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
				end
			end
			mmcspi_pkg::CMD_READ: begin
				rsp_d.send_valid = 1'b1;
				rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
			end
			mmcspi_pkg::CMD_WRITE: begin
				if (sec == 23'd0) begin
					rsp_d.done_res = 1'b1;
					rsp_d.status   = mmcspi_pkg::ST_SECTOR0;
				end else begin
					rsp_d.send_valid = 1'b1;
					rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
				end
			end
			default: begin
				case (phase_q)
					mmcspi_pkg::PH_CLOCK, mmcspi_pkg::PH_WTAIL: begin
						rsp_d.send_valid = 1'b1;
						rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
					end
					mmcspi_pkg::PH_FRAME: begin
						rsp_d.send_valid = 1'b1;
						rsp_d.send_byte  = (pos_inc < mmcspi_pkg::FRAME_BYTES)
							? mmcspi_pkg::frame_byte(pos_inc, op_q, sector_q)
							: mmcspi_pkg::BYTE_FILL;
					end
					mmcspi_pkg::PH_POLL: begin
						if (poll_done && res_fail) begin
							rsp_d.done_res = 1'b1;
							rsp_d.status   = res_code;
						end else if (poll_done && op_q == mmcspi_pkg::OP_WRITE) begin
							rsp_d.send_valid      = 1'b1;
							rsp_d.send_byte       = mmcspi_pkg::BYTE_TOKEN;
							rsp_d.payload_request = 1'b1;
						end else begin
							rsp_d.send_valid = 1'b1;
							rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
						end
					end
					mmcspi_pkg::PH_RTOKEN: begin
						if (miso != mmcspi_pkg::BYTE_TOKEN
								&& poll_inc >= mmcspi_pkg::TOKEN_POLLS) begin
							rsp_d.done_res = 1'b1;
							rsp_d.status   = mmcspi_pkg::ST_TOKEN;
						end else begin
							rsp_d.send_valid = 1'b1;
							rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
						end
					end
					mmcspi_pkg::PH_RDATA: begin
						rsp_d.read_byte  = miso;
						rsp_d.read_valid = 1'b1;
						rsp_d.byte_index = poll_q[8:0];
						rsp_d.send_valid = 1'b1;
						rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
					end
					mmcspi_pkg::PH_RCRC: begin
						if (pos_inc < mmcspi_pkg::RCRC_BYTES) begin
							rsp_d.send_valid = 1'b1;
							rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
						end else begin
							rsp_d.done_res = 1'b1;
						end
					end
					mmcspi_pkg::PH_WTOKEN: begin
						rsp_d.send_valid      = 1'b1;
						rsp_d.send_byte       = wbyte;
						rsp_d.payload_request = 1'b1;
						rsp_d.byte_index      = 9'd1;
					end
					mmcspi_pkg::PH_WDATA: begin
						rsp_d.send_valid = 1'b1;
						if (poll_inc < mmcspi_pkg::SECTOR_LEN) begin
							rsp_d.send_byte = wbyte;
							if (poll_inc2 < mmcspi_pkg::SECTOR_LEN) begin
								rsp_d.payload_request = 1'b1;
								rsp_d.byte_index      = poll_inc2[8:0];
							end
						end else begin
							rsp_d.send_byte = mmcspi_pkg::BYTE_FILL;
						end
					end
					mmcspi_pkg::PH_WBUSY: begin
						if (miso != 8'd0 || poll_inc >= mmcspi_pkg::BUSY_POLLS) begin
							rsp_d.done_res = 1'b1;
						end else begin
							rsp_d.send_valid = 1'b1;
							rsp_d.send_byte  = mmcspi_pkg::BYTE_FILL;
						end
					end
					default: begin
						rsp_d.send_valid = 1'b0;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mmcspi_pkg::PH_IDLE;
			op_q     <= mmcspi_pkg::OP_INIT_RST;
			pos_q    <= 5'd0;
			poll_q   <= 12'd0;
			att_q    <= 8'd0;
			sector_q <= 23'd0;
			sel_q    <= 1'b1;
			rsp_v_q  <= 1'b0;
			lim_q    <= mmcspi_pkg::INIT_ATTEMPTS_RESET;
		end else begin
			if (cfg.valid) begin
				lim_q <= cfg.data;
			end
			if (acc) begin
				phase_q  <= nx_phase;
				op_q     <= nx_op;
				pos_q    <= nx_pos;
				poll_q   <= nx_poll;
				att_q    <= nx_att;
				sector_q <= nx_sector;
				sel_q    <= nx_sel;
				rsp_v_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_d;
		end
	end

	a_read_selected: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q && rsp_q.read_valid |-> rsp_q.send_valid && !rsp_q.chip_select)
		else $error("read data with card deselected");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q && rsp_q.done_res |-> !rsp_q.busy_res && !rsp_q.send_valid)
		else $error("finished request still busy");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_v_q && rsp_q.busy_res == (phase_q != mmcspi_pkg::PH_IDLE))
		else $error("response missing or busy flag off state");

	a_write_selected: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mmcspi_pkg::PH_WTOKEN || phase_q == mmcspi_pkg::PH_WDATA
		|-> !sel_q)
		else $error("write payload with card deselected");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import mmcspi_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [4:0] ADDR_LAST_POS = 5'd20;
	localparam logic [22:0] SECTOR_MAX = 23'h7FFFFF;

	logic clk;
	logic arst_n;

	mmcspi_chan #(.T(req_t)) req_if ();
	mmcspi_chan #(.T(rsp_t)) rsp_if ();
	mmcspi_chan #(.T(logic [7:0])) cfg_if ();

	mmc_spi_sector_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	int src_idle;
	int sink_idle;
	int mismatches;
	int stall_cycles;
	rsp_t expected_rsp[$];
	rsp_t oldest_rsp;

	// card-side sequencer state as the host sees it
	phase_t      card_phase;
	op_t         card_op;
	logic [4:0]  frame_pos;
	logic [11:0] poll_cnt;
	logic [7:0]  try_cnt;
	logic [31:0] byte_addr;
	logic        cs_level;
	logic [7:0]  attempt_limit;
	rsp_t        next_rsp;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void drive_byte(input logic [7:0] b);
		next_rsp.send_valid = 1'b1;
		next_rsp.send_byte = b;
	endfunction

	function automatic void end_request(input logic [3:0] code);
		card_phase = PH_IDLE;
		next_rsp.done_res = 1'b1;
		next_rsp.status = code;
	endfunction

	function automatic void abort_request(input logic [3:0] code);
		cs_level = 1'b1;
		end_request(code);
	endfunction

	function automatic void open_frame();
		cs_level = 1'b0;
		card_phase = PH_FRAME;
		frame_pos = '0;
		drive_byte(BYTE_FILL);
	endfunction

	function automatic void open_clock();
		cs_level = 1'b1;
		card_phase = PH_CLOCK;
		frame_pos = '0;
		drive_byte(BYTE_FILL);
	endfunction

	function automatic logic [7:0] frame_out(input logic [4:0] pos);
		logic [31:0] addr;
		logic [7:0] b;
		addr = (card_op == OP_READ || card_op == OP_WRITE) ? byte_addr : 32'd0;
		if (pos < FRAME_CMD_POS) begin
			b = BYTE_FILL;
		end else if (pos == FRAME_CMD_POS) begin
			case (card_op)
				OP_INIT_RST: b = CMD_GO_IDLE;
				OP_INIT_IDLE: b = CMD_SEND_OP;
				OP_READ: b = CMD_RD_SINGLE;
				default: b = CMD_WR_SINGLE;
			endcase
		end else if (pos <= ADDR_LAST_POS) begin
			// address goes out most significant byte first
			b = 8'(addr >> (8 * (ADDR_LAST_POS - pos)));
		end else begin
			b = BYTE_CRC;
		end
		return b;
	endfunction

	function automatic void take_response(input logic [7:0] r);
		case (card_op)
			OP_INIT_RST: begin
				if (r == RSP_IDLE) begin
					card_op = OP_INIT_IDLE;
					try_cnt = '0;
					open_frame();
				end else begin
					try_cnt = try_cnt + 8'd1;
					if (try_cnt >= attempt_limit) abort_request(ST_INIT_RST);
					else open_clock();
				end
			end
			OP_INIT_IDLE: begin
				if (r == RSP_READY) begin
					abort_request(ST_OK);
				end else begin
					try_cnt = try_cnt + 8'd1;
					if (try_cnt >= attempt_limit) abort_request(ST_INIT_IDLE);
					else open_frame();
				end
			end
			default: begin
				if (r == RSP_INVALID) begin
					abort_request(card_op == OP_READ ? ST_RD_INVALID : ST_WR_INVALID);
				end else if (r != RSP_READY) begin
					abort_request(card_op == OP_READ ? ST_RD_GENERAL : ST_WR_GENERAL);
				end else if (card_op == OP_READ) begin
					card_phase = PH_RTOKEN;
					poll_cnt = '0;
					drive_byte(BYTE_FILL);
				end else begin
					card_phase = PH_WTOKEN;
					drive_byte(BYTE_TOKEN);
					next_rsp.payload_request = 1'b1;
					next_rsp.byte_index = '0;
				end
			end
		endcase
	endfunction

	function automatic void byte_event(input logic [7:0] miso, input logic [7:0] wbyte);
		logic init_op;
		logic [11:0] poll_limit;
		logic [7:0] good;
		logic [7:0] bad;
		init_op = (card_op == OP_INIT_RST || card_op == OP_INIT_IDLE);
		poll_limit = init_op ? INIT_POLLS : CMD_POLLS;
		good = (card_op == OP_INIT_RST) ? RSP_IDLE : RSP_READY;
		bad = init_op ? RSP_ERROR : RSP_INVALID;
		case (card_phase)
			PH_CLOCK: begin
				frame_pos = frame_pos + 5'd1;
				if (frame_pos < CLOCK_BYTES) drive_byte(BYTE_FILL);
				else open_frame();
			end
			PH_FRAME: begin
				frame_pos = frame_pos + 5'd1;
				if (frame_pos < FRAME_BYTES) begin
					drive_byte(frame_out(frame_pos));
				end else begin
					card_phase = PH_POLL;
					poll_cnt = '0;
					drive_byte(BYTE_FILL);
				end
			end
			PH_POLL: begin
				poll_cnt = poll_cnt + 12'd1;
				if (miso == good || miso == bad || poll_cnt >= poll_limit) take_response(miso);
				else drive_byte(BYTE_FILL);
			end
			PH_RTOKEN: begin
				poll_cnt = poll_cnt + 12'd1;
				if (miso == BYTE_TOKEN) begin
					card_phase = PH_RDATA;
					poll_cnt = '0;
					drive_byte(BYTE_FILL);
				end else if (poll_cnt >= TOKEN_POLLS) begin
					abort_request(ST_TOKEN);
				end else begin
					drive_byte(BYTE_FILL);
				end
			end
			PH_RDATA: begin
				next_rsp.read_byte = miso;
				next_rsp.read_valid = 1'b1;
				next_rsp.byte_index = poll_cnt[8:0];
				poll_cnt = poll_cnt + 12'd1;
				if (poll_cnt >= SECTOR_LEN) begin
					card_phase = PH_RCRC;
					frame_pos = '0;
				end
				drive_byte(BYTE_FILL);
			end
			PH_RCRC: begin
				frame_pos = frame_pos + 5'd1;
				if (frame_pos < RCRC_BYTES) drive_byte(BYTE_FILL);
				else abort_request(ST_OK);
			end
			PH_WTOKEN: begin
				card_phase = PH_WDATA;
				poll_cnt = '0;
				drive_byte(wbyte);
				next_rsp.payload_request = 1'b1;
				next_rsp.byte_index = 9'd1;
			end
			PH_WDATA: begin
				if (poll_cnt + 12'd1 < SECTOR_LEN) begin
					poll_cnt = poll_cnt + 12'd1;
					drive_byte(wbyte);
					// no request after the last payload byte
					if (poll_cnt + 12'd1 < SECTOR_LEN) begin
						next_rsp.payload_request = 1'b1;
						next_rsp.byte_index = 9'(poll_cnt + 12'd1);
					end
				end else begin
					card_phase = PH_WTAIL;
					frame_pos = '0;
					drive_byte(BYTE_FILL);
				end
			end
			PH_WTAIL: begin
				frame_pos = frame_pos + 5'd1;
				if (frame_pos >= WTAIL_BYTES) begin
					card_phase = PH_WBUSY;
					poll_cnt = '0;
				end
				drive_byte(BYTE_FILL);
			end
			PH_WBUSY: begin
				poll_cnt = poll_cnt + 12'd1;
				if (miso != 8'd0 || poll_cnt >= BUSY_POLLS) abort_request(ST_OK);
				else drive_byte(BYTE_FILL);
			end
			default: card_phase = PH_IDLE;
		endcase
	endfunction

	function automatic rsp_t predict_rsp(input req_t item);
		next_rsp = '0;
		case (item.cmd)
			CMD_INIT: begin
				card_op = OP_INIT_RST;
				try_cnt = '0;
				if (attempt_limit == 8'd0) abort_request(ST_INIT_RST);
				else open_clock();
			end
			CMD_READ: begin
				card_op = OP_READ;
				byte_addr = {item.sector, 9'd0};
				open_frame();
			end
			CMD_WRITE: begin
				// sector zero leaves chip select where it was
				if (item.sector == '0) begin
					end_request(ST_SECTOR0);
				end else begin
					card_op = OP_WRITE;
					byte_addr = {item.sector, 9'd0};
					open_frame();
				end
			end
			default: begin
				if (card_phase != PH_IDLE) byte_event(item.miso_byte, item.write_byte);
			end
		endcase
		next_rsp.chip_select = cs_level;
		next_rsp.busy_res = (card_phase != PH_IDLE);
		return next_rsp;
	endfunction

	function automatic req_t byte_req(input logic [7:0] miso);
		req_t r;
		r.cmd = CMD_BYTE;
		r.sector = 23'($urandom);
		r.miso_byte = miso;
		r.write_byte = 8'($urandom);
		return r;
	endfunction

	function automatic req_t start_req(input cmd_t c, input logic [22:0] sector);
		req_t r;
		r = byte_req(8'($urandom));
		r.cmd = c;
		r.sector = sector;
		return r;
	endfunction

	function automatic req_t random_start();
		req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		r = byte_req(8'($urandom));
		if (pick < 30) r.cmd = CMD_INIT;
		else if (pick < 65) r.cmd = CMD_READ;
		else r.cmd = CMD_WRITE;
		pick = $urandom_range(99);
		if (pick < 10) r.sector = '0;
		else if (pick < 20) r.sector = SECTOR_MAX;
		return r;
	endfunction

	// plays the card: mostly the answers that move the request along
	function automatic req_t card_reply(input bit noisy);
		int unsigned pick;
		logic [7:0] miso;
		req_t r;
		pick = $urandom_range(99);
		miso = 8'($urandom);
		case (card_phase)
			PH_POLL: begin
				if (pick < 55) begin
					miso = (card_op == OP_INIT_RST) ? RSP_IDLE : RSP_READY;
				end else if (pick < 65) begin
					if (card_op == OP_INIT_RST || card_op == OP_INIT_IDLE) miso = RSP_ERROR;
					else miso = RSP_INVALID;
				end else if (pick < 85) begin
					miso = BYTE_FILL;
				end
			end
			PH_RTOKEN: begin
				if (pick < 25) miso = BYTE_TOKEN;
				else if (pick < 90) miso = BYTE_FILL;
			end
			PH_WBUSY: begin
				if (pick >= 15) miso = RSP_READY;
			end
			default: ;
		endcase
		if (noisy && $urandom_range(999) < 2) r = random_start();
		else r = byte_req(miso);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	task automatic send_req(input req_t item);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= item;
		do @(posedge clk); while (!req_if.ready);
		expected_rsp.push_back(predict_rsp(item));
	endtask

	task automatic feed(input logic [7:0] miso, input phase_t stop_at);
		do send_req(byte_req(miso)); while (card_phase != stop_at && card_phase != PH_IDLE);
	endtask

	task automatic finish_request();
		while (card_phase != PH_IDLE) send_req(card_reply(1'b0));
	endtask

	task automatic settle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_attempts(input logic [7:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		attempt_limit = value;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic test_corner_requests();
		send_req(byte_req(8'h00));
		send_req(start_req(CMD_WRITE, '0));
		send_req(start_req(CMD_READ, SECTOR_MAX));
		repeat (3) send_req(byte_req(BYTE_FILL));
		// new start abandons the read
		send_req(start_req(CMD_WRITE, 23'd1));
		send_req(byte_req(8'hFF));
		send_req(start_req(CMD_INIT, SECTOR_MAX));
		send_req(byte_req(8'h00));
		// refused write while busy drops the request but keeps chip select
		send_req(start_req(CMD_READ, 23'h2AAAAA));
		repeat (2) send_req(byte_req(8'h00));
		send_req(start_req(CMD_WRITE, '0));
		send_req(byte_req(8'hFF));
		send_req(start_req(CMD_WRITE, 23'h555555));
		finish_request();
	endtask

	task automatic test_zero_attempts();
		settle();
		write_attempts(8'd0);
		send_req(start_req(CMD_INIT, '0));
		send_req(byte_req(8'h01));
		settle();
		write_attempts(INIT_ATTEMPTS_RESET);
		send_req(start_req(CMD_INIT, '0));
		finish_request();
	endtask

	task automatic test_timeouts();
		// reset command never answered
		send_req(start_req(CMD_INIT, '0));
		feed(BYTE_FILL, PH_IDLE);
		// idle command never answered
		send_req(start_req(CMD_INIT, '0));
		feed(BYTE_FILL, PH_POLL);
		feed(RSP_IDLE, PH_FRAME);
		feed(BYTE_FILL, PH_IDLE);
		// command response poll runs out
		send_req(start_req(CMD_READ, 23'h001234));
		feed(BYTE_FILL, PH_IDLE);
		send_req(start_req(CMD_READ, SECTOR_MAX));
		feed(BYTE_FILL, PH_POLL);
		feed(RSP_READY, PH_RTOKEN);
		feed(BYTE_FILL, PH_IDLE);
		// card stays busy for the whole poll window
		send_req(start_req(CMD_WRITE, SECTOR_MAX));
		feed(BYTE_FILL, PH_POLL);
		feed(RSP_READY, PH_WTOKEN);
		feed(BYTE_FILL, PH_WBUSY);
		feed(RSP_READY, PH_IDLE);
	endtask

	task automatic test_random_traffic(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			if (card_phase == PH_IDLE && $urandom_range(99) < 5) begin
				send_req(byte_req(8'($urandom)));
			end else begin
				if (card_phase == PH_IDLE) send_req(random_start());
				else send_req(card_reply(1'b1));
				sent++;
			end
		end
		finish_request();
	endtask

	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= sink_idle);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp.size() == 0) begin
				$error("response with no request pending");
				mismatches++;
			end else begin
				oldest_rsp = expected_rsp.pop_front();
				check_field("send_valid", oldest_rsp.send_valid, rsp_if.data.send_valid);
				check_field("send_byte", oldest_rsp.send_byte, rsp_if.data.send_byte);
				check_field("chip_select", oldest_rsp.chip_select, rsp_if.data.chip_select);
				check_field("read_byte", oldest_rsp.read_byte, rsp_if.data.read_byte);
				check_field("read_valid", oldest_rsp.read_valid, rsp_if.data.read_valid);
				check_field("payload_request", oldest_rsp.payload_request,
					rsp_if.data.payload_request);
				check_field("byte_index", oldest_rsp.byte_index, rsp_if.data.byte_index);
				check_field("done_res", oldest_rsp.done_res, rsp_if.data.done_res);
				check_field("status", oldest_rsp.status, rsp_if.data.status);
				check_field("busy_res", oldest_rsp.busy_res, rsp_if.data.busy_res);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		src_idle = 6;
		sink_idle = 85;
		mismatches = 0;
		stall_cycles = 0;
		card_phase = PH_IDLE;
		card_op = OP_INIT_RST;
		frame_pos = '0;
		poll_cnt = '0;
		try_cnt = '0;
		byte_addr = '0;
		cs_level = 1'b1;
		attempt_limit = INIT_ATTEMPTS_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_corner_requests();
		test_zero_attempts();
		settle();
		write_attempts(8'($urandom_range(2, 5)));
		test_random_traffic(2000);

		src_idle = 85;
		sink_idle = 6;
		settle();
		write_attempts(8'd255);
		test_random_traffic(1500);

		src_idle = 0;
		sink_idle = 0;
		settle();
		write_attempts(8'd1);
		test_timeouts();
		test_random_traffic(1500);
		settle();

		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
